// ===== rtl/dit_pkg.sv =====
`timescale 1ns / 1ps

package dit_pkg;

    // Default width of the two down-counters.
    localparam int COUNTER_WIDTH = 16;

    // Fixed field widths.
    localparam int OP_W       = 2;
    localparam int ELAPSED_W  = 16;
    localparam int LATCH_W    = 16;
    localparam int OUT_CNT_W  = 16;
    localparam int SRC_W      = 2;
    localparam int FLAGS_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Interrupt flag bit positions.
    localparam int OVF_BIT_A = 0;
    localparam int OVF_BIT_B = 1;

    // Opcodes of an input beat.
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LATCH_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONESHOT_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONESHOT_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_SOURCE  = 3'd4;

    // Timer B source codes at or above this value count timer A underflows.
    localparam logic [SRC_W-1:0] SRC_CASCADE = 2'd2;

    typedef enum logic {
        TMR_A = 1'b0,
        TMR_B = 1'b1
    } tmr_sel_t;

    typedef struct packed {
        logic     capture;
        logic     load_a;
        logic     load_b;
        logic     step;
        logic     reload;
        tmr_sel_t sel;
        logic     load_out;
    } dit_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            need_div;
        logic            skip_b;
        logic            rem_done;
    } dit_status_t;

endpackage

// ===== rtl/dit_rem.sv =====
`timescale 1ns / 1ps

module dit_rem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [dit_pkg::LATCH_W-1:0] dividend,
    input  logic [dit_pkg::LATCH_W-1:0] divisor,
    output logic                        done,
    output logic [dit_pkg::LATCH_W-1:0] rem
);

    localparam int W     = dit_pkg::LATCH_W;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_reg;
    logic [W-1:0]     q_reg;
    logic [W-1:0]     d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [W:0]   trial;
    logic         fits;
    logic [W-1:0] r_next;

    // One restoring step: bring in the next dividend bit, subtract if it fits.
    always_comb begin
        trial  = {r_reg, q_reg[W-1]};
        fits   = (trial >= {1'b0, d_reg});
        r_next = fits ? W'(trial - {1'b0, d_reg}) : W'(trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg <= '0;
            q_reg <= dividend;
            d_reg <= divisor;
        end else if (cnt_reg != '0) begin
            r_reg <= r_next;
            q_reg <= {q_reg[W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

// ===== rtl/dit_datapath.sv =====
`timescale 1ns / 1ps

module dit_datapath #(
    parameter int COUNTER_WIDTH = dit_pkg::COUNTER_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  dit_pkg::dit_cmd_t              cmd,
    output dit_pkg::dit_status_t           status,
    input  logic                           cfg_we,
    input  logic [dit_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dit_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [dit_pkg::OP_W-1:0]       s_opcode,
    input  logic [dit_pkg::ELAPSED_W-1:0]  s_elapsed_a,
    input  logic [dit_pkg::ELAPSED_W-1:0]  s_elapsed_b,
    output logic [dit_pkg::OUT_CNT_W-1:0]  m_count_a,
    output logic [dit_pkg::OUT_CNT_W-1:0]  m_count_b,
    output logic                           m_run_a,
    output logic                           m_run_b,
    output logic                           m_underflow_a,
    output logic                           m_underflow_b,
    output logic [dit_pkg::FLAGS_W-1:0]    m_irq_flags
);

    localparam int W     = COUNTER_WIDTH;
    localparam int EW    = dit_pkg::ELAPSED_W;
    localparam int LW    = dit_pkg::LATCH_W;
    localparam int OW    = dit_pkg::OUT_CNT_W;
    localparam int CMP_W = (W > EW) ? W : EW;

    // Configuration.
    logic [LW-1:0]               latch_a_reg;
    logic [LW-1:0]               latch_b_reg;
    logic                        oneshot_a_reg;
    logic                        oneshot_b_reg;
    logic [dit_pkg::SRC_W-1:0]   src_reg;

    // Timer state.
    logic [W-1:0]                counter_a_reg;
    logic [W-1:0]                counter_b_reg;
    logic                        run_a_reg;
    logic                        run_b_reg;
    logic [dit_pkg::FLAGS_W-1:0] flags_reg;
    logic                        uf_a_reg;
    logic                        uf_b_reg;

    // Captured input beat.
    logic [dit_pkg::OP_W-1:0]    op_reg;
    logic [EW-1:0]               ea_reg;
    logic [EW-1:0]               eb_reg;

    // Output register.
    logic [OW-1:0]               out_count_a_reg;
    logic [OW-1:0]               out_count_b_reg;
    logic                        out_run_a_reg;
    logic                        out_run_b_reg;
    logic                        out_uf_a_reg;
    logic                        out_uf_b_reg;
    logic [dit_pkg::FLAGS_W-1:0] out_flags_reg;

    // Selected timer.
    logic          cascade;
    logic [W-1:0]  cur_count;
    logic          cur_run;
    logic [EW-1:0] cur_ticks;
    logic [LW-1:0] cur_latch;
    logic          cur_oneshot;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] ticks_ext;
    logic          rest_pos;
    logic [W-1:0]  diff;
    logic [LW-1:0] deficit;
    logic          underflow;
    logic          need_div;
    logic [W-1:0]  reload_val;

    logic          rem_start;
    logic          rem_done;
    logic [LW-1:0] rem_val;

    always_comb begin
        cascade = (src_reg >= dit_pkg::SRC_CASCADE);
        if (cmd.sel == dit_pkg::TMR_A) begin
            cur_count   = counter_a_reg;
            cur_run     = run_a_reg;
            cur_ticks   = ea_reg;
            cur_latch   = latch_a_reg;
            cur_oneshot = oneshot_a_reg;
        end else begin
            cur_count   = counter_b_reg;
            cur_run     = run_b_reg;
            // In cascade, timer B sees one tick per timer A underflow.
            cur_ticks   = cascade ? EW'(1) : eb_reg;
            cur_latch   = latch_b_reg;
            cur_oneshot = oneshot_b_reg;
        end
        count_ext  = CMP_W'(cur_count);
        ticks_ext  = CMP_W'(cur_ticks);
        rest_pos   = (count_ext > ticks_ext);
        diff       = W'(count_ext - ticks_ext);
        // Only used when ticks >= count, so the deficit fits the tick width.
        deficit    = LW'(ticks_ext - count_ext);
        underflow  = cur_run && !rest_pos;
        need_div   = underflow && !cur_oneshot && (cur_latch != '0);
        reload_val = W'(cur_latch - rem_val);
    end

    assign rem_start = cmd.step && need_div;

    dit_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (deficit),
        .divisor  (cur_latch),
        .done     (rem_done),
        .rem      (rem_val)
    );

    always_comb begin
        status.op       = op_reg;
        status.need_div = need_div;
        status.skip_b   = cascade && !uf_a_reg;
        status.rem_done = rem_done;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_a_reg   <= '1;
            latch_b_reg   <= '1;
            oneshot_a_reg <= 1'b0;
            oneshot_b_reg <= 1'b0;
            src_reg       <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                dit_pkg::CFG_LATCH_A:   latch_a_reg   <= cfg_wdata[LW-1:0];
                dit_pkg::CFG_LATCH_B:   latch_b_reg   <= cfg_wdata[LW-1:0];
                dit_pkg::CFG_ONESHOT_A: oneshot_a_reg <= cfg_wdata[0];
                dit_pkg::CFG_ONESHOT_B: oneshot_b_reg <= cfg_wdata[0];
                dit_pkg::CFG_B_SOURCE:  src_reg       <= cfg_wdata[dit_pkg::SRC_W-1:0];
                default: ;
            endcase
        end
    end

    // Timer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_a_reg <= '0;
            counter_b_reg <= '0;
            run_a_reg     <= 1'b0;
            run_b_reg     <= 1'b0;
            flags_reg     <= '0;
            uf_a_reg      <= 1'b0;
            uf_b_reg      <= 1'b0;
        end else begin
            if (cmd.capture) begin
                uf_a_reg <= 1'b0;
                uf_b_reg <= 1'b0;
            end
            if (cmd.load_a) begin
                counter_a_reg <= W'(latch_a_reg);
                run_a_reg     <= 1'b1;
            end
            if (cmd.load_b) begin
                counter_b_reg <= W'(latch_b_reg);
                run_b_reg     <= 1'b1;
            end
            if (cmd.step && cur_run) begin
                if (rest_pos) begin
                    if (cmd.sel == dit_pkg::TMR_A) begin
                        counter_a_reg <= diff;
                    end else begin
                        counter_b_reg <= diff;
                    end
                end else begin
                    // A continuous reload with a nonzero latch is finished by
                    // the remainder unit; the other cases settle here.
                    if (cmd.sel == dit_pkg::TMR_A) begin
                        uf_a_reg                     <= 1'b1;
                        flags_reg[dit_pkg::OVF_BIT_A] <= 1'b1;
                        if (cur_oneshot) begin
                            run_a_reg     <= 1'b0;
                            counter_a_reg <= '0;
                        end else if (!need_div) begin
                            counter_a_reg <= '0;
                        end
                    end else begin
                        uf_b_reg                     <= 1'b1;
                        flags_reg[dit_pkg::OVF_BIT_B] <= 1'b1;
                        if (cur_oneshot) begin
                            run_b_reg     <= 1'b0;
                            counter_b_reg <= '0;
                        end else if (!need_div) begin
                            counter_b_reg <= '0;
                        end
                    end
                end
            end
            if (cmd.reload) begin
                if (cmd.sel == dit_pkg::TMR_A) begin
                    counter_a_reg <= reload_val;
                end else begin
                    counter_b_reg <= reload_val;
                end
            end
        end
    end

    // Input capture and output register.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= s_opcode;
            ea_reg <= s_elapsed_a;
            eb_reg <= s_elapsed_b;
        end
        if (cmd.load_out) begin
            out_count_a_reg <= OW'(counter_a_reg);
            out_count_b_reg <= OW'(counter_b_reg);
            out_run_a_reg   <= run_a_reg;
            out_run_b_reg   <= run_b_reg;
            out_uf_a_reg    <= uf_a_reg;
            out_uf_b_reg    <= uf_b_reg;
            out_flags_reg   <= flags_reg;
        end
    end

    assign m_count_a     = out_count_a_reg;
    assign m_count_b     = out_count_b_reg;
    assign m_run_a       = out_run_a_reg;
    assign m_run_b       = out_run_b_reg;
    assign m_underflow_a = out_uf_a_reg;
    assign m_underflow_b = out_uf_b_reg;
    assign m_irq_flags   = out_flags_reg;

endmodule

// ===== rtl/dit_ctrl.sv =====
`timescale 1ns / 1ps

module dit_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  dit_pkg::dit_status_t status,
    output dit_pkg::dit_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_STEP_A,
        ST_DIV_A,
        ST_STEP_B,
        ST_DIV_B,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd          = '0;
        cmd.sel      = dit_pkg::TMR_A;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_valid && s_ready_reg;
            end
            ST_DISPATCH: begin
                cmd.load_a = (status.op == dit_pkg::OP_LOAD_A);
                cmd.load_b = (status.op == dit_pkg::OP_LOAD_B);
            end
            ST_STEP_A: begin
                cmd.step = 1'b1;
            end
            ST_DIV_A: begin
                cmd.reload = status.rem_done;
            end
            ST_STEP_B: begin
                cmd.sel  = dit_pkg::TMR_B;
                cmd.step = !status.skip_b;
            end
            ST_DIV_B: begin
                cmd.sel    = dit_pkg::TMR_B;
                cmd.reload = status.rem_done;
            end
            ST_FINISH: begin
                cmd.load_out = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (cmd.capture) begin
                        s_ready_reg <= 1'b0;
                        state_reg   <= ST_DISPATCH;
                    end
                end
                ST_DISPATCH: begin
                    if (status.op == dit_pkg::OP_ADVANCE) begin
                        state_reg <= ST_STEP_A;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_STEP_A: begin
                    state_reg <= status.need_div ? ST_DIV_A : ST_STEP_B;
                end
                ST_DIV_A: begin
                    if (status.rem_done) begin
                        state_reg <= ST_STEP_B;
                    end
                end
                ST_STEP_B: begin
                    if (!status.skip_b && status.need_div) begin
                        state_reg <= ST_DIV_B;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_DIV_B: begin
                    if (status.rem_done) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (cmd.load_out) begin
                        m_valid_reg <= 1'b1;
                        s_ready_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/dual_interval_timer_cascade.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Beat contents
// s_        in         s_valid / s_ready  opcode, elapsed_a, elapsed_b
// m_        out        m_valid / m_ready  count_a/b, run_a/b, underflow_a/b, irq_flags
// cfg_      in         cfg_we             cfg_index, cfg_wdata (no read-back)
//
// One input beat is worked on at a time. A load or unused opcode goes through dispatch
// and finish; m_valid rises and the next beat can be accepted once the output register
// is free. An advance steps timer A, then timer B (in cascade only on an A underflow);
// each continuous reload waits on the radix-2 remainder unit shared by both timers.
// Reset is synchronous to aclk and active low; it stops both timers and clears the
// flags. A stalled result waits in the output register while the next beat is
// accepted and worked on.

module dual_interval_timer_cascade #(
    parameter int COUNTER_WIDTH = dit_pkg::COUNTER_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [dit_pkg::OP_W-1:0]       s_opcode,
    input  logic [dit_pkg::ELAPSED_W-1:0]  s_elapsed_a,
    input  logic [dit_pkg::ELAPSED_W-1:0]  s_elapsed_b,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dit_pkg::OUT_CNT_W-1:0]  m_count_a,
    output logic [dit_pkg::OUT_CNT_W-1:0]  m_count_b,
    output logic                           m_run_a,
    output logic                           m_run_b,
    output logic                           m_underflow_a,
    output logic                           m_underflow_b,
    output logic [dit_pkg::FLAGS_W-1:0]    m_irq_flags,
    input  logic                           cfg_we,
    input  logic [dit_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dit_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    dit_pkg::dit_cmd_t    cmd;
    dit_pkg::dit_status_t status;

    dit_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dit_datapath #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_opcode      (s_opcode),
        .s_elapsed_a   (s_elapsed_a),
        .s_elapsed_b   (s_elapsed_b),
        .m_count_a     (m_count_a),
        .m_count_b     (m_count_b),
        .m_run_a       (m_run_a),
        .m_run_b       (m_run_b),
        .m_underflow_a (m_underflow_a),
        .m_underflow_b (m_underflow_b),
        .m_irq_flags   (m_irq_flags)
    );

    // Only one beat is in flight, so ready drops right after an acceptance.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat was still in flight");

    // An underflow reported in a result must be reflected in the sticky flags.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_underflow_a |-> m_irq_flags[dit_pkg::OVF_BIT_A])
        else $error("timer A underflow without its sticky flag");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_underflow_b |-> m_irq_flags[dit_pkg::OVF_BIT_B])
        else $error("timer B underflow without its sticky flag");

endmodule
